// ===== src/rwp_pkg.sv =====
// Shared types and constants for the RIFF/WAVE PCM parser.
`timescale 1ns / 1ps

package rwp_pkg;

  // Four-character codes, first file byte in the top bits
  localparam logic [31:0] ID_RIFF = 32'h5249_4646;
  localparam logic [31:0] ID_WAVE = 32'h5741_5645;
  localparam logic [31:0] ID_FMT  = 32'h666D_7420;
  localparam logic [31:0] ID_DATA = 32'h6461_7461;

  localparam logic [31:0] FMT_BYTES        = 32'd16;
  localparam logic [31:0] DEFAULT_MAX_DATA = 32'd67108864;  // 64 MiB

  // Byte counter inside the RIFF header, chunk headers and fmt body
  localparam int unsigned CNT_W = 4;

  localparam int unsigned TDATA_W = 160;
  localparam int unsigned TUSER_W = 2;

  // Result codes
  localparam logic [3:0] ERR_NONE         = 4'd0;
  localparam logic [3:0] ERR_RIFF_TRUNC   = 4'd1;
  localparam logic [3:0] ERR_NOT_WAVE     = 4'd2;
  localparam logic [3:0] ERR_FMT_TRUNC    = 4'd3;
  localparam logic [3:0] ERR_FMT_TAG      = 4'd4;
  localparam logic [3:0] ERR_DATA_EMPTY   = 4'd5;
  localparam logic [3:0] ERR_DATA_LARGE   = 4'd6;
  localparam logic [3:0] ERR_DATA_TRUNC   = 4'd7;
  localparam logic [3:0] ERR_NO_FMT       = 4'd8;
  localparam logic [3:0] ERR_NO_DATA      = 4'd9;
  localparam logic [3:0] ERR_BAD_FORMAT   = 4'd10;
  localparam logic [3:0] ERR_BAD_BITS     = 4'd11;

  localparam logic [15:0] PCM_TAG = 16'd1;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_RIFF = 5'b00001,
    PH_HDR  = 5'b00010,
    PH_FMT  = 5'b00100,
    PH_SKIP = 5'b01000,
    PH_DATA = 5'b10000
  } phase_e;

  // One result beat as it leaves on the master side
  typedef struct packed {
    logic [TUSER_W-1:0] user;
    logic [TDATA_W-1:0] data;
  } res_t;

endpackage

// ===== src/riff_wave_pcm_parser.sv =====
// RIFF/WAVE PCM parser top level: header check, chunk walk, sample stream, report.
//
// Channel   Dir  Beat           Contents
// s_axis    in   file byte      tlast = end marker, tdata[7:0] = byte value
// m_axis    out  sample/report  tuser = kind, chunk start; tdata = sample and report fields
// cfg       in   write only     max_data_bytes
//
// One input transfer is taken every cycle while the skid stage is empty; each byte
// updates the parse state in the same cycle and any result is registered in the
// output register, or in the skid stage while the output is stalled. Both sit on the
// master side, so a stalled result does not block input until both are full.
// Reset clears the parse control state, the output stages and sets max_data_bytes
// to 64 MiB; the shifter and held format fields are always written before use.
`timescale 1ns / 1ps

module riff_wave_pcm_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] byte_value
  input  logic                        s_axis_tlast,   // end_marker
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [7:0] sample_byte, [11:8] error_code, [27:12] channel_count, [59:28] rate_hz,
  // [91:60] bytes_per_second, [107:92] frame_align, [123:108] sample_bits,
  // [155:124] data_length, [159:156] zero
  output logic [rwp_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic [rwp_pkg::TUSER_W-1:0] m_axis_tuser,   // [0] kind, [1] chunk_start
  input  logic                        cfg_we_i,
  input  logic [31:0]                 cfg_wdata_i
);

  // Configuration
  logic [31:0] max_data_q;

  // Parse state
  rwp_pkg::phase_e            phase_q, phase_d;
  logic [rwp_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [31:0]                chunk_len_q, chunk_len_d;
  logic [63:0]                shift_q, shift_d;
  logic [15:0]                channels_q, channels_d;
  logic [31:0]                rate_q, rate_d;
  logic [31:0]                byte_rate_q, byte_rate_d;
  logic [15:0]                align_q, align_d;
  logic [15:0]                bits_q, bits_d;
  logic [31:0]                data_len_q, data_len_d;
  logic                       seen_fmt_q, seen_fmt_d;
  logic                       seen_data_q, seen_data_d;
  logic                       pad_q, pad_d;
  logic [3:0]                 sticky_q, sticky_d;

  // Output stages
  rwp_pkg::res_t out_q, skid_q, res;
  logic          out_valid_q, skid_valid_q, res_valid;

  logic        in_acc;
  logic [31:0] hdr_size;
  logic [31:0] skip_len;
  logic [3:0]  rep_err;

  assign s_axis_tready = !skid_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Chunk size, little-endian in the last four header bytes (current byte on top)
  assign hdr_size = {s_axis_tdata, shift_q[7:0], shift_q[15:8], shift_q[23:16]};
  assign skip_len = chunk_len_q - rwp_pkg::FMT_BYTES;

  // Report code: first error in file order, then the final checks
  always_comb begin
    rep_err = sticky_q;
    if (rep_err == rwp_pkg::ERR_NONE) begin
      if (phase_q == rwp_pkg::PH_RIFF)      rep_err = rwp_pkg::ERR_RIFF_TRUNC;
      else if (phase_q == rwp_pkg::PH_FMT)  rep_err = rwp_pkg::ERR_FMT_TRUNC;
      else if (phase_q == rwp_pkg::PH_DATA) rep_err = rwp_pkg::ERR_DATA_TRUNC;
      else if (!seen_fmt_q)                 rep_err = rwp_pkg::ERR_NO_FMT;
      else if (!seen_data_q)                rep_err = rwp_pkg::ERR_NO_DATA;
      else if (channels_q == 16'd0 || rate_q == 32'd0 ||
               align_q == 16'd0 || byte_rate_q == 32'd0) begin
        rep_err = rwp_pkg::ERR_BAD_FORMAT;
      end else if (bits_q != 16'd8 && bits_q != 16'd16) begin
        rep_err = rwp_pkg::ERR_BAD_BITS;
      end
    end
  end

  // Per-byte parse step and result forming
  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    chunk_len_d = chunk_len_q;
    shift_d     = shift_q;
    channels_d  = channels_q;
    rate_d      = rate_q;
    byte_rate_d = byte_rate_q;
    align_d     = align_q;
    bits_d      = bits_q;
    data_len_d  = data_len_q;
    seen_fmt_d  = seen_fmt_q;
    seen_data_d = seen_data_q;
    pad_d       = pad_q;
    sticky_d    = sticky_q;
    res_valid   = 1'b0;
    res.user    = '0;
    res.data    = '0;

    if (in_acc) begin
      if (s_axis_tlast) begin
        // End of file: one report, then back to the start
        res_valid = 1'b1;
        res.user  = 2'b01;
        if (rep_err == rwp_pkg::ERR_NONE) begin
          res.data = {4'd0, data_len_q, bits_q, align_q, byte_rate_q, rate_q,
                      channels_q, rep_err, 8'd0};
        end else begin
          res.data[11:8] = rep_err;
        end
        phase_d     = rwp_pkg::PH_RIFF;
        cnt_d       = '0;
        chunk_len_d = '0;
        seen_fmt_d  = 1'b0;
        seen_data_d = 1'b0;
        pad_d       = 1'b0;
        sticky_d    = rwp_pkg::ERR_NONE;
      end else if (sticky_q == rwp_pkg::ERR_NONE) begin
        case (phase_q)
          // RIFF....WAVE header
          rwp_pkg::PH_RIFF: begin
            shift_d = {shift_q[55:0], s_axis_tdata};
            cnt_d   = cnt_q + 4'd1;
            if (cnt_q == 4'd3) begin
              chunk_len_d = shift_d[31:0];
            end
            if (cnt_q == 4'd11) begin
              if (chunk_len_q != rwp_pkg::ID_RIFF || shift_d[31:0] != rwp_pkg::ID_WAVE) begin
                sticky_d = rwp_pkg::ERR_NOT_WAVE;
              end else begin
                phase_d     = rwp_pkg::PH_HDR;
                cnt_d       = '0;
                chunk_len_d = '0;
              end
            end
          end
          // Chunk header: fourcc then size
          rwp_pkg::PH_HDR: begin
            shift_d = {shift_q[55:0], s_axis_tdata};
            cnt_d   = cnt_q + 4'd1;
            if (cnt_q == 4'd7) begin
              cnt_d = '0;
              if (shift_d[63:32] == rwp_pkg::ID_FMT) begin
                if (hdr_size < rwp_pkg::FMT_BYTES) begin
                  sticky_d = rwp_pkg::ERR_FMT_TRUNC;
                end else begin
                  chunk_len_d = hdr_size;
                  phase_d     = rwp_pkg::PH_FMT;
                end
              end else if (shift_d[63:32] == rwp_pkg::ID_DATA) begin
                if (hdr_size == 32'd0) begin
                  sticky_d = rwp_pkg::ERR_DATA_EMPTY;
                end else if (hdr_size > max_data_q) begin
                  sticky_d = rwp_pkg::ERR_DATA_LARGE;
                end else begin
                  data_len_d  = hdr_size;
                  chunk_len_d = hdr_size;
                  pad_d       = hdr_size[0];
                  phase_d     = rwp_pkg::PH_DATA;
                end
              end else begin
                chunk_len_d = hdr_size;
                pad_d       = hdr_size[0];
                phase_d     = (hdr_size == 32'd0 && !hdr_size[0]) ? rwp_pkg::PH_HDR
                                                                  : rwp_pkg::PH_SKIP;
              end
            end
          end
          // 16 format bytes, little-endian fields shifted in from the top
          rwp_pkg::PH_FMT: begin
            cnt_d = cnt_q + 4'd1;
            if (cnt_q == 4'd0)       shift_d = {56'd0, s_axis_tdata};
            else if (cnt_q == 4'd1)  shift_d[15:8] = s_axis_tdata;
            else if (cnt_q < 4'd4)   channels_d  = {s_axis_tdata, channels_q[15:8]};
            else if (cnt_q < 4'd8)   rate_d      = {s_axis_tdata, rate_q[31:8]};
            else if (cnt_q < 4'd12)  byte_rate_d = {s_axis_tdata, byte_rate_q[31:8]};
            else if (cnt_q < 4'd14)  align_d     = {s_axis_tdata, align_q[15:8]};
            else                     bits_d      = {s_axis_tdata, bits_q[15:8]};
            if (cnt_q == 4'd15) begin
              cnt_d = '0;
              if (shift_q[15:0] != rwp_pkg::PCM_TAG) begin
                sticky_d = rwp_pkg::ERR_FMT_TAG;
              end else begin
                seen_fmt_d  = 1'b1;
                chunk_len_d = skip_len;
                pad_d       = chunk_len_q[0];
                phase_d     = (skip_len == 32'd0 && !chunk_len_q[0]) ? rwp_pkg::PH_HDR
                                                                     : rwp_pkg::PH_SKIP;
              end
            end
          end
          // Skipped body, then the pad byte of an odd chunk
          rwp_pkg::PH_SKIP: begin
            if (chunk_len_q != 32'd0) chunk_len_d = chunk_len_q - 32'd1;
            else                      pad_d       = 1'b0;
            if (chunk_len_d == 32'd0 && !pad_d) begin
              phase_d = rwp_pkg::PH_HDR;
              cnt_d   = '0;
            end
          end
          // Data body: every byte goes out as a sample
          rwp_pkg::PH_DATA: begin
            res_valid        = 1'b1;
            res.user         = {(cnt_q == '0), 1'b0};
            res.data[7:0]    = s_axis_tdata;
            cnt_d            = 4'd1;
            if (chunk_len_q != 32'd0) chunk_len_d = chunk_len_q - 32'd1;
            if (chunk_len_d == 32'd0) begin
              seen_data_d = 1'b1;
              cnt_d       = '0;
              phase_d     = pad_q ? rwp_pkg::PH_SKIP : rwp_pkg::PH_HDR;
            end
          end
          default: begin
            phase_d = rwp_pkg::PH_RIFF;
          end
        endcase
      end
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_data_q <= rwp_pkg::DEFAULT_MAX_DATA;
    end else if (cfg_we_i) begin
      max_data_q <= cfg_wdata_i;
    end
  end

  // Parse control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= rwp_pkg::PH_RIFF;
      cnt_q       <= '0;
      chunk_len_q <= '0;
      seen_fmt_q  <= 1'b0;
      seen_data_q <= 1'b0;
      pad_q       <= 1'b0;
      sticky_q    <= rwp_pkg::ERR_NONE;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      chunk_len_q <= chunk_len_d;
      seen_fmt_q  <= seen_fmt_d;
      seen_data_q <= seen_data_d;
      pad_q       <= pad_d;
      sticky_q    <= sticky_d;
    end
  end

  // Header shifter and held format fields; only read once fully written
  always_ff @(posedge clk_i) begin
    shift_q     <= shift_d;
    channels_q  <= channels_d;
    rate_q      <= rate_d;
    byte_rate_q <= byte_rate_d;
    align_q     <= align_d;
    bits_q      <= bits_d;
    data_len_q  <= data_len_d;
  end

  // Output register and skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.data;
  assign m_axis_tuser  = out_q.user;

  // Checks
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a result while the output register is empty");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (out_valid_q && skid_valid_q))
    else $error("input stalled with room in the output stages");

  a_report_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast) |=> (phase_q == rwp_pkg::PH_RIFF &&
                                  sticky_q == rwp_pkg::ERR_NONE && cnt_q == '0))
    else $error("parser did not restart after the end marker");

  a_no_sample_after_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !s_axis_tlast && sticky_q != rwp_pkg::ERR_NONE) |-> !res_valid)
    else $error("result produced after a sticky error");

endmodule
